@@ design/msb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants of the four-core snooping coherence bus.
// ----------------------------------------------------------------------------
package msb_pkg;

	localparam int CORE_COUNT_DEF    = 4;
	localparam int INDEX_BITS_DEF    = 6;
	localparam int MEM_ADDR_BITS_DEF = 20;

	localparam int ADDR_W = 20;
	localparam int DATA_W = 32;
	localparam int CORE_W = 2;
	localparam int LAT_W  = 8;
	localparam int OWN_W  = 3;

	localparam logic [LAT_W-1:0] LAT_RESET = 8'd16;
	localparam logic [OWN_W-1:0] OWNER_MEM = 3'd4;

	typedef enum logic [1:0] {ST_I, ST_S, ST_E, ST_M} line_st_t;
	typedef enum logic [1:0] {BUS_IDLE, BUS_RD, BUS_RDX, BUS_FLUSH} bus_cmd_t;
	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_ACC_EV, B_GRANT_EV, B_BUS, B_SNP_EV, B_FL_EV, B_FIN, B_RES
	} back_st_t;
	typedef enum logic {IT_ACCESS, IT_TICK} item_kind_t;

	typedef struct packed {
		item_kind_t        kind;
		logic [CORE_W-1:0] core;
		logic              is_write;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [CORE_W-1:0] core;
		logic              wr;
		logic [DATA_W-1:0] data;
	} res_t;

endpackage
`default_nettype wire

@@ design/msb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msb_front
// Takes requests, classifies them as access or tick, holds two for the back.
// ----------------------------------------------------------------------------
module msb_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic                        command,
	input  wire logic [msb_pkg::CORE_W-1:0]  core,
	input  wire logic                        is_write,
	input  wire logic [msb_pkg::ADDR_W-1:0]  address,
	input  wire logic [msb_pkg::DATA_W-1:0]  write_data,
	output logic                             q_full,
	output logic                             q_empty,
	input  wire logic                        take,
	output msb_pkg::item_t                   item
);
	msb_pkg::item_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	msb_pkg::item_t wr_item;

	always_comb begin
		wr_item.kind       = command ? msb_pkg::IT_TICK : msb_pkg::IT_ACCESS;
		wr_item.core       = core;
		wr_item.is_write   = is_write;
		wr_item.address    = address;
		wr_item.write_data = write_data;
	end

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign item    = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= ~wp_q;
			end
			if (take) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, take};
		end
	end
endmodule
`default_nettype wire

@@ design/msb_res_q.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msb_res_q
// Two-entry queue of completed accesses towards the result side.
// ----------------------------------------------------------------------------
module msb_res_q (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_en,
	input  msb_pkg::res_t       push_res,
	output logic                q_full,
	output logic                q_empty,
	input  wire logic           pop_en,
	output msb_pkg::res_t       head
);
	msb_pkg::res_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign head    = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_en) begin
			slot_q[wp_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_en) begin
				wp_q <= ~wp_q;
			end
			if (pop_en) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push_en} - {1'b0, pop_en};
		end
	end
endmodule
`default_nettype wire

@@ design/msb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msb_back
// Caches, bus sequencer, arbiter and main memory; takes one request or tick at a time.
// ----------------------------------------------------------------------------
module msb_back #(
	parameter int CORE_COUNT    = msb_pkg::CORE_COUNT_DEF,
	parameter int INDEX_BITS    = msb_pkg::INDEX_BITS_DEF,
	parameter int MEM_ADDR_BITS = msb_pkg::MEM_ADDR_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [msb_pkg::LAT_W-1:0]  mem_latency,
	input  wire logic                       item_empty,
	input  msb_pkg::item_t                  item,
	output logic                            item_take,
	input  wire logic                       res_full,
	output logic                            res_push,
	output msb_pkg::res_t                   res_d,
	output logic                            clearing
);
	localparam int CB    = (CORE_COUNT > 2) ? 2 : 1;
	localparam int IB    = INDEX_BITS;
	localparam int MA    = MEM_ADDR_BITS;
	localparam int TW    = MA - IB - 2;
	localparam int LA    = CB + IB;
	localparam int CA    = LA + 2;
	localparam int LINES = 1 << IB;
	localparam int MWORDS = 1 << MA;

	localparam logic [msb_pkg::OWN_W-1:0] OWN_CC = msb_pkg::OWN_W'(CORE_COUNT);
	localparam logic [CB-1:0] LAST_CORE = CB'(CORE_COUNT - 1);

	// memories
	logic [TW-1:0]              tag_mem [CORE_COUNT*LINES];
	logic [msb_pkg::DATA_W-1:0] cw_mem  [CORE_COUNT*LINES*4];
	logic [msb_pkg::DATA_W-1:0] mm_mem  [MWORDS];

	logic              tag_re, tag_we;
	logic [LA-1:0]     tag_ra, tag_wa;
	logic [TW-1:0]     tag_wd, tag_rd;
	logic              cw_re, cw_we;
	logic [CA-1:0]     cw_ra, cw_wa;
	logic [msb_pkg::DATA_W-1:0] cw_wd, cw_rd;
	logic              mm_re, mm_we;
	logic [MA-1:0]     mm_ra, mm_wa;
	logic [msb_pkg::DATA_W-1:0] mm_wd, mm_rd;

	// line states, set to invalid by the clearing pass
	msb_pkg::line_st_t st_mem [CORE_COUNT*LINES];
	logic              st_re, st_we;
	logic [LA-1:0]     st_ra;
	logic [CB-1:0]     st_wc;
	logic [IB-1:0]     st_wi;
	msb_pkg::line_st_t st_wv, st_rd;

	msb_pkg::back_st_t state_q, state_d;
	msb_pkg::bus_cmd_t cmd_q, cmd_d;
	logic [msb_pkg::OWN_W-1:0]  own_q, own_d;
	logic [MA-1:0]              bwa_q, bwa_d;
	logic [1:0]                 wc_q, wc_d;
	logic [msb_pkg::LAT_W-1:0]  lat_q, lat_d;
	logic                       snoop_q, snoop_d, shared_q, shared_d;
	logic [msb_pkg::CORE_W-1:0] srv_q, srv_d;
	logic [CB-1:0]              sn_i_q, sn_i_d, sn_own_q, sn_own_d;
	logic                       sn_hit_q, sn_hit_d;
	logic [MA-1:0]              clr_q, clr_d;
	logic                       pv_q [CORE_COUNT];
	logic                       pv_d [CORE_COUNT];
	logic [msb_pkg::CORE_W-1:0] prio_q [CORE_COUNT];
	logic [msb_pkg::CORE_W-1:0] prio_d [CORE_COUNT];

	// payload
	logic [msb_pkg::CORE_W-1:0] cur_core_q;
	logic                       cur_wr_q;
	logic [MA-1:0]              cur_addr_q;
	logic [msb_pkg::DATA_W-1:0] cur_data_q;
	logic                       pw_q [CORE_COUNT];
	logic [MA-1:0]              pa_q [CORE_COUNT];
	logic [msb_pkg::DATA_W-1:0] pd_q [CORE_COUNT];
	logic                       cur_ld, pend_ld;

	// helpers
	logic [CB-1:0]  s_idx, cur_c, own_idx, g_p;
	logic [MA-1:0]  pa_s, it_a;
	logic [IB-1:0]  idx_a, idx_w, cur_idx;
	logic [TW-1:0]  tag_a, cur_tag;
	logic [1:0]     off_a;
	logic           own_core, in_range, g_found, own_is_srv;
	logic [msb_pkg::CORE_W-1:0] g_c;
	msb_pkg::line_st_t cur_st, sn_st;
	logic [msb_pkg::DATA_W-1:0] fl_val;
	logic           sn_m, sn_found;

	assign s_idx    = srv_q[CB-1:0];
	assign pa_s     = pa_q[s_idx];
	assign idx_a    = pa_s[IB+1:2];
	assign tag_a    = pa_s[MA-1:IB+2];
	assign off_a    = pa_s[1:0];
	assign idx_w    = bwa_q[IB+1:2];
	assign own_core = (own_q < OWN_CC);
	assign own_idx  = own_q[CB-1:0];
	assign own_is_srv = (own_q == {1'b0, srv_q});
	assign cur_c    = cur_core_q[CB-1:0];
	assign cur_idx  = cur_addr_q[IB+1:2];
	assign cur_tag  = cur_addr_q[MA-1:IB+2];
	assign cur_st   = st_rd;
	assign it_a     = MA'(item.address);
	assign in_range = ({1'b0, item.core} < 3'(CORE_COUNT));
	assign fl_val   = own_core ? cw_rd : mm_rd;
	assign sn_st    = st_rd;
	assign sn_m     = (sn_i_q != s_idx) && (tag_rd == tag_a) && (sn_st == msb_pkg::ST_M);
	assign sn_found = sn_hit_q || sn_m;
	assign clearing = (state_q == msb_pkg::B_CLEAR);

	// round robin: highest index of the order wins
	always_comb begin
		g_found = 1'b0;
		g_p     = '0;
		g_c     = '0;
		for (int p = 0; p < CORE_COUNT; p++) begin
			if (({1'b0, prio_q[p]} < 3'(CORE_COUNT)) && pv_q[prio_q[p][CB-1:0]]) begin
				g_found = 1'b1;
				g_p     = CB'(p);
				g_c     = prio_q[p];
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		own_d    = own_q;
		bwa_d    = bwa_q;
		wc_d     = wc_q;
		lat_d    = lat_q;
		snoop_d  = snoop_q;
		shared_d = shared_q;
		srv_d    = srv_q;
		sn_i_d   = sn_i_q;
		sn_own_d = sn_own_q;
		sn_hit_d = sn_hit_q;
		clr_d    = clr_q;
		pv_d     = pv_q;
		prio_d   = prio_q;
		tag_re = 1'b0; tag_ra = '0; tag_we = 1'b0; tag_wa = '0; tag_wd = '0;
		cw_re  = 1'b0; cw_ra  = '0; cw_we  = 1'b0; cw_wa  = '0; cw_wd  = '0;
		mm_re  = 1'b0; mm_ra  = '0; mm_we  = 1'b0; mm_wa  = '0; mm_wd  = '0;
		st_re  = 1'b0; st_ra  = '0;
		st_we  = 1'b0; st_wc  = '0; st_wi  = '0; st_wv = msb_pkg::ST_I;
		res_push = 1'b0;
		res_d    = '0;
		item_take = 1'b0;
		cur_ld   = 1'b0;
		pend_ld  = 1'b0;

		case (state_q)
			msb_pkg::B_CLEAR: begin
				mm_we = 1'b1;
				mm_wa = clr_q;
				st_we = 1'b1;
				st_wc = clr_q[LA-1:IB];
				st_wi = clr_q[IB-1:0];
				clr_d = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = msb_pkg::B_IDLE;
				end
			end
			msb_pkg::B_IDLE: begin
				if (!item_empty && !res_full) begin
					item_take = 1'b1;
					if (item.kind == msb_pkg::IT_ACCESS) begin
						if (in_range && !pv_q[item.core[CB-1:0]] &&
						    !(cmd_q != msb_pkg::BUS_IDLE && srv_q == item.core)) begin
							cur_ld  = 1'b1;
							tag_re  = 1'b1;
							tag_ra  = {item.core[CB-1:0], it_a[IB+1:2]};
							st_re   = 1'b1;
							st_ra   = {item.core[CB-1:0], it_a[IB+1:2]};
							cw_re   = 1'b1;
							cw_ra   = {item.core[CB-1:0], it_a[IB+1:0]};
							state_d = msb_pkg::B_ACC_EV;
						end
					end else if (cmd_q == msb_pkg::BUS_IDLE) begin
						if (g_found) begin
							for (int j = 0; j < CORE_COUNT; j++) begin
								if (CB'(j) <= g_p) begin
									prio_d[j] = (j == 0) ? g_c : prio_q[(j == 0) ? 0 : j - 1];
								end
							end
							srv_d = g_c;
							pv_d[g_c[CB-1:0]] = 1'b0;
							tag_re  = 1'b1;
							tag_ra  = {g_c[CB-1:0], pa_q[g_c[CB-1:0]][IB+1:2]};
							st_re   = 1'b1;
							st_ra   = {g_c[CB-1:0], pa_q[g_c[CB-1:0]][IB+1:2]};
							state_d = msb_pkg::B_GRANT_EV;
						end
					end else begin
						state_d = msb_pkg::B_BUS;
					end
				end
			end
			msb_pkg::B_ACC_EV: begin
				state_d = msb_pkg::B_IDLE;
				if (!cur_wr_q && tag_rd == cur_tag && cur_st != msb_pkg::ST_I) begin
					res_push = 1'b1;
					res_d    = '{core: cur_core_q, wr: 1'b0, data: cw_rd};
				end else if (cur_wr_q && tag_rd == cur_tag &&
				             (cur_st == msb_pkg::ST_M || cur_st == msb_pkg::ST_E)) begin
					cw_we = 1'b1;
					cw_wa = {cur_c, cur_addr_q[IB+1:0]};
					cw_wd = cur_data_q;
					st_we = 1'b1; st_wc = cur_c; st_wi = cur_idx; st_wv = msb_pkg::ST_M;
					res_push = 1'b1;
					res_d    = '{core: cur_core_q, wr: 1'b1, data: '0};
				end else begin
					pv_d[cur_c] = 1'b1;
					pend_ld     = 1'b1;
				end
			end
			msb_pkg::B_GRANT_EV: begin
				state_d = msb_pkg::B_BUS;
				if (st_rd == msb_pkg::ST_M && tag_rd != tag_a) begin
					// victim write-back first
					cmd_d    = msb_pkg::BUS_FLUSH;
					own_d    = {1'b0, srv_q};
					bwa_d    = {tag_rd, idx_a, 2'b00};
					wc_d     = 2'd0;
					snoop_d  = 1'b0;
					shared_d = 1'b0;
				end else begin
					cmd_d    = pw_q[s_idx] ? msb_pkg::BUS_RDX : msb_pkg::BUS_RD;
					lat_d    = mem_latency;
					snoop_d  = 1'b1;
					shared_d = 1'b0;
					wc_d     = 2'd0;
					bwa_d    = {pa_s[MA-1:2], 2'b00};
				end
			end
			msb_pkg::B_BUS: begin
				if (cmd_q == msb_pkg::BUS_FLUSH) begin
					if (own_core) begin
						cw_re = 1'b1;
						cw_ra = {own_idx, idx_w, wc_q};
					end else begin
						mm_re = 1'b1;
						mm_ra = {bwa_q[MA-1:2], wc_q};
					end
					state_d = msb_pkg::B_FL_EV;
				end else if (snoop_q) begin
					snoop_d  = 1'b0;
					sn_i_d   = '0;
					sn_hit_d = 1'b0;
					sn_own_d = '0;
					tag_re   = 1'b1;
					tag_ra   = {{CB{1'b0}}, idx_a};
					st_re    = 1'b1;
					st_ra    = {{CB{1'b0}}, idx_a};
					state_d  = msb_pkg::B_SNP_EV;
				end else if (lat_q != '0) begin
					lat_d   = lat_q - 1'b1;
					state_d = msb_pkg::B_IDLE;
				end else begin
					cmd_d   = msb_pkg::BUS_FLUSH;
					own_d   = msb_pkg::OWNER_MEM;
					wc_d    = 2'd0;
					mm_re   = 1'b1;
					mm_ra   = {bwa_q[MA-1:2], 2'b00};
					state_d = msb_pkg::B_FL_EV;
				end
			end
			msb_pkg::B_SNP_EV: begin
				if (sn_i_q != s_idx && tag_rd == tag_a && sn_st != msb_pkg::ST_I) begin
					if (sn_m) begin
						sn_hit_d = 1'b1;
						sn_own_d = sn_i_q;
					end else begin
						shared_d = 1'b1;
					end
					st_we = 1'b1; st_wc = sn_i_q; st_wi = idx_a;
					st_wv = (cmd_q == msb_pkg::BUS_RDX) ? msb_pkg::ST_I : msb_pkg::ST_S;
				end
				if (sn_i_q == LAST_CORE) begin
					if (sn_found) begin
						cmd_d   = msb_pkg::BUS_FLUSH;
						own_d   = msb_pkg::OWN_W'(sn_m ? sn_i_q : sn_own_q);
						wc_d    = 2'd0;
						state_d = msb_pkg::B_IDLE;
					end else begin
						state_d = msb_pkg::B_BUS;
					end
				end else begin
					sn_i_d = sn_i_q + 1'b1;
					tag_re = 1'b1;
					tag_ra = {sn_i_q + 1'b1, idx_a};
					st_re  = 1'b1;
					st_ra  = {sn_i_q + 1'b1, idx_a};
				end
			end
			msb_pkg::B_FL_EV: begin
				if (own_core) begin
					mm_we = 1'b1;
					mm_wa = {bwa_q[MA-1:2], wc_q};
					mm_wd = fl_val;
				end
				if (!own_is_srv) begin
					cw_we = 1'b1;
					cw_wa = {s_idx, idx_w, wc_q};
					cw_wd = fl_val;
				end
				if (wc_q != 2'd3) begin
					wc_d    = wc_q + 1'b1;
					state_d = msb_pkg::B_IDLE;
				end else begin
					wc_d = 2'd0;
					if (own_is_srv) begin
						st_we = 1'b1; st_wc = s_idx; st_wi = idx_w; st_wv = msb_pkg::ST_I;
						cmd_d    = pw_q[s_idx] ? msb_pkg::BUS_RDX : msb_pkg::BUS_RD;
						lat_d    = mem_latency;
						snoop_d  = 1'b1;
						shared_d = 1'b0;
						bwa_d    = {pa_s[MA-1:2], 2'b00};
						state_d  = msb_pkg::B_IDLE;
					end else begin
						tag_we  = 1'b1;
						tag_wa  = {s_idx, idx_a};
						tag_wd  = tag_a;
						state_d = msb_pkg::B_FIN;
					end
				end
			end
			msb_pkg::B_FIN: begin
				st_we = 1'b1; st_wc = s_idx; st_wi = idx_a;
				if (pw_q[s_idx]) begin
					cw_we = 1'b1;
					cw_wa = {s_idx, idx_a, off_a};
					cw_wd = pd_q[s_idx];
					st_wv = msb_pkg::ST_M;
					res_push = 1'b1;
					res_d    = '{core: srv_q, wr: 1'b1, data: '0};
					cmd_d    = msb_pkg::BUS_IDLE;
					snoop_d  = 1'b0;
					shared_d = 1'b0;
					state_d  = msb_pkg::B_IDLE;
				end else begin
					st_wv = (shared_q || own_core) ? msb_pkg::ST_S : msb_pkg::ST_E;
					cw_re   = 1'b1;
					cw_ra   = {s_idx, idx_a, off_a};
					state_d = msb_pkg::B_RES;
				end
			end
			msb_pkg::B_RES: begin
				res_push = 1'b1;
				res_d    = '{core: srv_q, wr: 1'b0, data: cw_rd};
				cmd_d    = msb_pkg::BUS_IDLE;
				snoop_d  = 1'b0;
				shared_d = 1'b0;
				state_d  = msb_pkg::B_IDLE;
			end
			default: begin
				state_d = msb_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= msb_pkg::B_CLEAR;
			cmd_q    <= msb_pkg::BUS_IDLE;
			own_q    <= '0;
			bwa_q    <= '0;
			wc_q     <= '0;
			lat_q    <= '0;
			snoop_q  <= 1'b0;
			shared_q <= 1'b0;
			srv_q    <= '0;
			sn_i_q   <= '0;
			sn_own_q <= '0;
			sn_hit_q <= 1'b0;
			clr_q    <= '0;
			for (int i = 0; i < CORE_COUNT; i++) begin
				pv_q[i]   <= 1'b0;
				prio_q[i] <= msb_pkg::CORE_W'(i);
			end
		end else begin
			state_q  <= state_d;
			cmd_q    <= cmd_d;
			own_q    <= own_d;
			bwa_q    <= bwa_d;
			wc_q     <= wc_d;
			lat_q    <= lat_d;
			snoop_q  <= snoop_d;
			shared_q <= shared_d;
			srv_q    <= srv_d;
			sn_i_q   <= sn_i_d;
			sn_own_q <= sn_own_d;
			sn_hit_q <= sn_hit_d;
			clr_q    <= clr_d;
			pv_q     <= pv_d;
			prio_q   <= prio_d;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[{st_wc, st_wi}] <= st_wv;
		end
		if (st_re) begin
			st_rd <= st_mem[st_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cur_ld) begin
			cur_core_q <= item.core;
			cur_wr_q   <= item.is_write;
			cur_addr_q <= it_a;
			cur_data_q <= item.write_data;
		end
		if (pend_ld) begin
			pw_q[cur_c] <= cur_wr_q;
			pa_q[cur_c] <= cur_addr_q;
			pd_q[cur_c] <= cur_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (tag_re) begin
			tag_rd <= tag_mem[tag_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cw_we) begin
			cw_mem[cw_wa] <= cw_wd;
		end
		if (cw_re) begin
			cw_rd <= cw_mem[cw_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (mm_we) begin
			mm_mem[mm_wa] <= mm_wd;
		end
		if (mm_re) begin
			mm_rd <= mm_mem[mm_ra];
		end
	end
endmodule
`default_nettype wire

@@ design/mesi_snoop_bus_four_cores_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mesi_snoop_bus_four_cores_unit
// Four direct-mapped caches on one snooping MESI bus to word memory.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// request  | push / full        | command core is_write address write_data
// result   | pop / empty        | done_core done_write read_data
// config   | cfg_valid/cfg_ready| cfg_data (memory latency)
//
// an access passes the back sequencer in its idle and access-evaluate states;
// a tick advances the bus transaction: the snoop walks the tag memory one core a
// cycle, and a fill word passes one memory read and one write. after reset a
// clearing pass zeroes main memory and invalidates every line, with full held
// high; config is taken at any time. two-entry queues on both sides let either
// side stall alone.
// ----------------------------------------------------------------------------
module mesi_snoop_bus_four_cores_unit #(
	parameter int CORE_COUNT    = msb_pkg::CORE_COUNT_DEF,
	parameter int INDEX_BITS    = msb_pkg::INDEX_BITS_DEF,
	parameter int MEM_ADDR_BITS = msb_pkg::MEM_ADDR_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic                        command,
	input  wire logic [msb_pkg::CORE_W-1:0]  core,
	input  wire logic                        is_write,
	input  wire logic [msb_pkg::ADDR_W-1:0]  address,
	input  wire logic [msb_pkg::DATA_W-1:0]  write_data,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [msb_pkg::CORE_W-1:0]       done_core,
	output logic                             done_write,
	output logic [msb_pkg::DATA_W-1:0]       read_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [msb_pkg::LAT_W-1:0]   cfg_data
);
	logic [msb_pkg::LAT_W-1:0] lat_cfg_q;
	logic fq_full, fq_empty, item_take, res_full, res_push, clearing, in_wr;
	msb_pkg::item_t item;
	msb_pkg::res_t  res_d, head;

	assign cfg_ready = 1'b1;
	assign full      = fq_full | clearing;
	assign in_wr     = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_cfg_q <= msb_pkg::LAT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lat_cfg_q <= cfg_data;
		end
	end

	msb_front u_front (
		.clk(clk), .arst_n(arst_n), .wr_en(in_wr),
		.command(command), .core(core), .is_write(is_write),
		.address(address), .write_data(write_data),
		.q_full(fq_full), .q_empty(fq_empty), .take(item_take), .item(item)
	);

	msb_back #(
		.CORE_COUNT(CORE_COUNT), .INDEX_BITS(INDEX_BITS), .MEM_ADDR_BITS(MEM_ADDR_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .mem_latency(lat_cfg_q),
		.item_empty(fq_empty), .item(item), .item_take(item_take),
		.res_full(res_full), .res_push(res_push), .res_d(res_d), .clearing(clearing)
	);

	msb_res_q u_res_q (
		.clk(clk), .arst_n(arst_n), .push_en(res_push), .push_res(res_d),
		.q_full(res_full), .q_empty(empty), .pop_en(pop & ~empty), .head(head)
	);

	assign done_core  = head.core;
	assign done_write = head.wr;
	assign read_data  = head.data;

	// no result into a full queue
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into full queue");

	// the back only takes a request that is there
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> !fq_empty) else $error("request taken from empty queue");

	// nothing accepted while memory is being cleared
	a_clear_full: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (full && !item_take)) else $error("request taken during clear");

	// a write result never carries data
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_d.wr) |-> (res_d.data == '0)) else $error("write result has data");
endmodule
`default_nettype wire
